>>> rtl/fcwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwc_pkg
// Shared types and constants for the footprint clearance window check.
// ----------------------------------------------------------------------------
package fcwc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_SPAN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_SPAN = 3'd3;

  localparam int EXTENT_RST = 600;
  localparam int SPAN_RST   = 1;

  // result field widths
  localparam int IDX_W = 10;

  // per-column occupancy count, wraps
  localparam int CNT_W = 7;

  // window geometry of one raster position
  typedef struct packed {
    logic row0;     // first row of the frame, counts restart
    logic leave_l;  // a row drops out of the long column window
    logic leave_s;  // a row drops out of the short column window
    logic edge_l;   // lengthwise window sits inside the margins
    logic edge_x;   // crosswise window sits inside the margins
  } pos_flags_t;

endpackage

>>> rtl/fcwc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwc_cfg
// Configuration registers; values are clamped to the supported range on write.
// ----------------------------------------------------------------------------
module fcwc_cfg
  import fcwc_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  parameter int MAX_SPAN = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  output logic [$clog2(MAX_ROWS+1)-1:0] rows_lim,
  output logic [$clog2(MAX_COLS+1)-1:0] cols_lim,
  output logic [$clog2(MAX_SPAN)-1:0]   span_long,
  output logic [$clog2(MAX_SPAN)-1:0]   span_short
);

  localparam int RLW = $clog2(MAX_ROWS + 1);
  localparam int CLW = $clog2(MAX_COLS + 1);
  localparam int SW  = $clog2(MAX_SPAN);

  localparam int RowsRst = (EXTENT_RST > MAX_ROWS) ? MAX_ROWS : EXTENT_RST;
  localparam int ColsRst = (EXTENT_RST > MAX_COLS) ? MAX_COLS : EXTENT_RST;
  localparam int SpanRst = (SPAN_RST >= MAX_SPAN) ? MAX_SPAN - 1 : SPAN_RST;

  logic [RLW-1:0] rows_lim_r, rows_lim_nxt;
  logic [CLW-1:0] cols_lim_r, cols_lim_nxt;
  logic [SW-1:0]  span_long_r, span_long_nxt;
  logic [SW-1:0]  span_short_r, span_short_nxt;

  int rows_val, cols_val, span_val;
  logic wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;

  always_comb begin
    // for the extents zero acts as one, anything above the maximum as the maximum
    if (cfg_wdata == '0) begin
      rows_val = 1;
      cols_val = 1;
    end else begin
      rows_val = (int'(cfg_wdata) > MAX_ROWS) ? MAX_ROWS : int'(cfg_wdata);
      cols_val = (int'(cfg_wdata) > MAX_COLS) ? MAX_COLS : int'(cfg_wdata);
    end
    span_val = (int'(cfg_wdata[5:0]) >= MAX_SPAN) ? MAX_SPAN - 1 : int'(cfg_wdata[5:0]);
  end

  always_comb begin
    rows_lim_nxt   = rows_lim_r;
    cols_lim_nxt   = cols_lim_r;
    span_long_nxt  = span_long_r;
    span_short_nxt = span_short_r;
    if (wr_en) begin
      unique case (cfg_index)
        REG_GRID_ROWS:  rows_lim_nxt   = RLW'(rows_val);
        REG_GRID_COLS:  cols_lim_nxt   = CLW'(cols_val);
        REG_LONG_SPAN:  span_long_nxt  = SW'(span_val);
        REG_SHORT_SPAN: span_short_nxt = SW'(span_val);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_lim_r   <= RLW'(RowsRst);
      cols_lim_r   <= CLW'(ColsRst);
      span_long_r  <= SW'(SpanRst);
      span_short_r <= SW'(SpanRst);
    end else begin
      rows_lim_r   <= rows_lim_nxt;
      cols_lim_r   <= cols_lim_nxt;
      span_long_r  <= span_long_nxt;
      span_short_r <= span_short_nxt;
    end
  end

  assign rows_lim   = rows_lim_r;
  assign cols_lim   = cols_lim_r;
  assign span_long  = span_long_r;
  assign span_short = span_short_r;

endmodule

>>> rtl/fcwc_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwc_raster
// Raster position counters, history ring slots and window geometry flags.
// ----------------------------------------------------------------------------
module fcwc_raster
  import fcwc_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  parameter int MAX_SPAN = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [$clog2(MAX_ROWS+1)-1:0] rows_lim,
  input  logic [$clog2(MAX_COLS+1)-1:0] cols_lim,
  input  logic [$clog2(MAX_SPAN)-1:0]   span_long,
  input  logic [$clog2(MAX_SPAN)-1:0]   span_short,
  output logic [$clog2(MAX_ROWS)-1:0]   pos_row,
  output logic [$clog2(MAX_COLS)-1:0]   pos_col,
  output logic [$clog2(MAX_SPAN)-1:0]   wr_slot,
  output logic [$clog2(MAX_SPAN)-1:0]   rd_slot_l,
  output logic [$clog2(MAX_SPAN)-1:0]   rd_slot_s,
  output pos_flags_t                    pos_flags
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int SW  = $clog2(MAX_SPAN);
  localparam int RLW = $clog2(MAX_ROWS + 1);
  localparam int CLW = $clog2(MAX_COLS + 1);

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic          col_last, row_last;

  assign col_last = (CLW'(col_r) + CLW'(1)) >= cols_lim;
  assign row_last = (RLW'(row_r) + RLW'(1)) >= rows_lim;

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (advance) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + RW'(1);
          slot_nxt = (slot_r == SW'(MAX_SPAN - 1)) ? '0 : slot_r + SW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // slot of row (r - span - 1) in the ring of MAX_SPAN rows
  always_comb begin
    if (slot_r > span_long) begin
      rd_slot_l = slot_r - span_long - SW'(1);
    end else begin
      rd_slot_l = slot_r + (SW'(MAX_SPAN - 1) - span_long);
    end
    if (slot_r > span_short) begin
      rd_slot_s = slot_r - span_short - SW'(1);
    end else begin
      rd_slot_s = slot_r + (SW'(MAX_SPAN - 1) - span_short);
    end
  end

  always_comb begin
    pos_flags.row0    = (row_r == '0);
    pos_flags.leave_l = (row_r > span_long);
    pos_flags.leave_s = (row_r > span_short);
    pos_flags.edge_l  = (row_r > span_long) && (col_r > span_short);
    pos_flags.edge_x  = (row_r > span_short) && (col_r > span_long);
  end

  assign pos_row = row_r;
  assign pos_col = col_r;
  assign wr_slot = slot_r;

endmodule

>>> rtl/fcwc_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwc_window
// Three-register pipe: input register, column count update with the history
// and count memories, and the result register. Zero runs along the row
// decide the two window flags.
// ----------------------------------------------------------------------------
module fcwc_window
  import fcwc_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  parameter int MAX_SPAN = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_accept,
  output logic                        in_stall,
  input  logic                        in_cell,
  input  logic [$clog2(MAX_ROWS)-1:0] pos_row,
  input  logic [$clog2(MAX_COLS)-1:0] pos_col,
  input  logic [$clog2(MAX_SPAN)-1:0] wr_slot,
  input  logic [$clog2(MAX_SPAN)-1:0] rd_slot_l,
  input  logic [$clog2(MAX_SPAN)-1:0] rd_slot_s,
  input  pos_flags_t                  pos_flags,
  input  logic [$clog2(MAX_SPAN)-1:0] span_long,
  input  logic [$clog2(MAX_SPAN)-1:0] span_short,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [IDX_W-1:0]            out_row,
  output logic [IDX_W-1:0]            out_col,
  output logic                        out_fit_l,
  output logic                        out_fit_x
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int SW  = $clog2(MAX_SPAN);
  localparam int CLW = $clog2(MAX_COLS + 1);
  localparam int RNW = $clog2(MAX_SPAN + 1);
  localparam int PW  = 2 * CNT_W;

  // history ring and per-column counts {short, long}
  logic          hist_mem [MAX_SPAN][MAX_COLS];
  logic [PW-1:0] cnt_mem  [MAX_COLS];

  // stage 0
  logic          s0_valid_r, s0_valid_nxt;
  logic          s0_bit_r;
  logic [RW-1:0] s0_row_r;
  logic [CW-1:0] s0_col_r;
  logic [SW-1:0] s0_wslot_r, s0_rslot_l_r, s0_rslot_s_r;
  pos_flags_t    s0_flags_r;

  // stage 1
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_bit_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  pos_flags_t    s1_flags_r;
  logic          s1_hist_l_r, s1_hist_s_r;
  logic [PW-1:0] s1_cnt_rd_r;
  logic          s1_cnt_ok_r;
  logic          s1_fwd_hit_r;
  logic [PW-1:0] s1_fwd_val_r;

  // columns written since reset form a prefix; entries past it read as zero
  logic [CLW-1:0] fill_r, fill_nxt;

  logic [RNW-1:0] run_l_r, run_l_nxt;
  logic [RNW-1:0] run_x_r, run_x_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_row_r, out_col_r;
  logic             out_fit_l_r, out_fit_x_r;

  logic             adv1, adv2;
  logic [PW-1:0]    cnt_base, cnt_new;
  logic [CNT_W-1:0] cnt_l, cnt_s;
  logic             leave_l, leave_s;
  logic             fit_l, fit_x;

  assign adv2     = s1_valid_r & (~out_valid_r | ~out_stall);
  assign adv1     = s0_valid_r & (~s1_valid_r | adv2);
  assign in_stall = s0_valid_r & ~adv1;

  assign s0_valid_nxt  = in_accept ? 1'b1 : (adv1 ? 1'b0 : s0_valid_r);
  assign s1_valid_nxt  = adv1 ? 1'b1 : (adv2 ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv2 ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  assign fill_nxt = (adv1 && (CLW'(s0_col_r) >= fill_r)) ? CLW'(s0_col_r) + CLW'(1) : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      run_l_r     <= '0;
      run_x_r     <= '0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      run_l_r     <= run_l_nxt;
      run_x_r     <= run_x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_bit_r     <= in_cell;
      s0_row_r     <= pos_row;
      s0_col_r     <= pos_col;
      s0_wslot_r   <= wr_slot;
      s0_rslot_l_r <= rd_slot_l;
      s0_rslot_s_r <= rd_slot_s;
      s0_flags_r   <= pos_flags;
    end
  end

  // history ring: read-first, so a full-depth span sees the old row
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_hist_l_r <= hist_mem[s0_rslot_l_r][s0_col_r];
      s1_hist_s_r <= hist_mem[s0_rslot_s_r][s0_col_r];
      hist_mem[s0_wslot_r][s0_col_r] <= s0_bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_cnt_rd_r <= cnt_mem[s0_col_r];
    end
    if (adv2) begin
      cnt_mem[s1_col_r] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_bit_r     <= s0_bit_r;
      s1_row_r     <= s0_row_r;
      s1_col_r     <= s0_col_r;
      s1_flags_r   <= s0_flags_r;
      s1_cnt_ok_r  <= CLW'(s0_col_r) < fill_r;
      // count written back in this same cycle bypasses the memory
      s1_fwd_hit_r <= adv2 && (s1_col_r == s0_col_r);
      s1_fwd_val_r <= cnt_new;
    end
  end

  always_comb begin
    if (s1_fwd_hit_r) begin
      cnt_base = s1_fwd_val_r;
    end else if (s1_cnt_ok_r) begin
      cnt_base = s1_cnt_rd_r;
    end else begin
      cnt_base = '0;
    end
    leave_l = s1_flags_r.leave_l & s1_hist_l_r;
    leave_s = s1_flags_r.leave_s & s1_hist_s_r;
    if (s1_flags_r.row0) begin
      cnt_l = CNT_W'(s1_bit_r);
      cnt_s = CNT_W'(s1_bit_r);
    end else begin
      cnt_l = cnt_base[CNT_W-1:0] + CNT_W'(s1_bit_r) - CNT_W'(leave_l);
      cnt_s = cnt_base[PW-1:CNT_W] + CNT_W'(s1_bit_r) - CNT_W'(leave_s);
    end
    cnt_new = {cnt_s, cnt_l};
  end

  // runs of zero column counts ending at this column, saturating
  always_comb begin
    run_l_nxt = run_l_r;
    run_x_nxt = run_x_r;
    if (adv2) begin
      if (cnt_l != '0) begin
        run_l_nxt = '0;
      end else if (run_l_r != RNW'(MAX_SPAN)) begin
        run_l_nxt = run_l_r + RNW'(1);
      end
      if (cnt_s != '0) begin
        run_x_nxt = '0;
      end else if (run_x_r != RNW'(MAX_SPAN)) begin
        run_x_nxt = run_x_r + RNW'(1);
      end
    end
  end

  assign fit_l = s1_flags_r.edge_l && (run_l_nxt > RNW'(span_short));
  assign fit_x = s1_flags_r.edge_x && (run_x_nxt > RNW'(span_long));

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_row_r   <= IDX_W'(s1_row_r);
      out_col_r   <= IDX_W'(s1_col_r);
      out_fit_l_r <= fit_l;
      out_fit_x_r <= fit_x;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_fit_l = out_fit_l_r;
  assign out_fit_x = out_fit_x_r;

endmodule

>>> rtl/footprint_clearance_window_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// footprint_clearance_window_check_core
// Streaming box-sum check of two footprint windows over an occupancy grid.
// ----------------------------------------------------------------------------
// Cells enter on the in_ channel in raster order, row outer, column inner,
// one bit per beat. Each beat yields one out_ beat with the cell's row and
// column and two flags: the long-by-short and the short-by-long window ending
// at the cell are free and clear of the low-side margin row and column.
// Grid extents and spans are written on the cfg_ channel (index 0..3:
// rows, cols, long span, short span) while no beat is in flight;
// cfg_ready is always high.
// An accepted beat passes the input, count and result registers to out_.
// Throughput: one beat per cycle unless out_stall holds the result register,
// bounded by the single port pair of the history ring and count memory (one
// read-modify-write per column per beat). out_stall holds the result register;
// up to two more beats are taken into the input and count stages before in_stall rises.
// Reset clears the raster position and pipe state and loads 600 x 600 with
// spans of 1. No clearing pass: count entries not yet written read as zero.
// ----------------------------------------------------------------------------
module footprint_clearance_window_check_core
  import fcwc_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  parameter int MAX_SPAN = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cell_occupied,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      out_row_index,
  output logic [IDX_W-1:0]      out_col_index,
  output logic                  out_fits_lengthwise,
  output logic                  out_fits_crosswise,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int SW  = $clog2(MAX_SPAN);
  localparam int RLW = $clog2(MAX_ROWS + 1);
  localparam int CLW = $clog2(MAX_COLS + 1);

  logic [RLW-1:0] rows_lim;
  logic [CLW-1:0] cols_lim;
  logic [SW-1:0]  span_long, span_short;
  logic [RW-1:0]  pos_row;
  logic [CW-1:0]  pos_col;
  logic [SW-1:0]  wr_slot, rd_slot_l, rd_slot_s;
  pos_flags_t     pos_flags;
  logic           in_accept;

  assign in_accept = in_valid & ~in_stall;

  fcwc_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_SPAN (MAX_SPAN)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .rows_lim   (rows_lim),
    .cols_lim   (cols_lim),
    .span_long  (span_long),
    .span_short (span_short)
  );

  fcwc_raster #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_SPAN (MAX_SPAN)
  ) u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (in_accept),
    .rows_lim   (rows_lim),
    .cols_lim   (cols_lim),
    .span_long  (span_long),
    .span_short (span_short),
    .pos_row    (pos_row),
    .pos_col    (pos_col),
    .wr_slot    (wr_slot),
    .rd_slot_l  (rd_slot_l),
    .rd_slot_s  (rd_slot_s),
    .pos_flags  (pos_flags)
  );

  fcwc_window #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_SPAN (MAX_SPAN)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_stall   (in_stall),
    .in_cell    (in_cell_occupied),
    .pos_row    (pos_row),
    .pos_col    (pos_col),
    .wr_slot    (wr_slot),
    .rd_slot_l  (rd_slot_l),
    .rd_slot_s  (rd_slot_s),
    .pos_flags  (pos_flags),
    .span_long  (span_long),
    .span_short (span_short),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row_index),
    .out_col    (out_col_index),
    .out_fit_l  (out_fits_lengthwise),
    .out_fit_x  (out_fits_crosswise)
  );

endmodule

>>> verif/tb_footprint_clearance_window_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_footprint_clearance_window_check_core
// Self-checking bench for the footprint clearance window check core.
// ----------------------------------------------------------------------------
// A queue-fed driver streams occupancy cells in raster order. A clocked
// monitor keeps its own ring of row bits, per-column counts and the row of
// recent column counts, predicts both window flags for every accepted cell
// and compares each out_ beat in order. Grid extents and spans change
// between frames, and at times mid-frame (the column extent may only shrink,
// so no history entry is read before it is written).
// ----------------------------------------------------------------------------
module tb_footprint_clearance_window_check_core;
  import fcwc_pkg::*;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;
  localparam int MAX_SPAN = 64;
  localparam int SPAN_W   = 6;
  localparam int CLK_HALF = 4;

  // indexes past the last register: writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_SHORT_SPAN + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             fit_l;
    logic             fit_x;
  } clearance_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_cell_occupied = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [IDX_W-1:0]      out_row_index;
  logic [IDX_W-1:0]      out_col_index;
  logic                  out_fits_lengthwise;
  logic                  out_fits_crosswise;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit          cell_q[$];
  reg_write_t  reg_q[$];
  clearance_t  clearance_q[$];
  int unsigned send_gap_pct = 19;
  int unsigned recv_stall_pct = 68;
  int unsigned mismatches = 0;
  int unsigned cells_planned = 0;
  int unsigned cells_taken = 0;
  int unsigned regs_planned = 0;
  int unsigned regs_taken = 0;
  int unsigned random_cells = 0;

  // predicted block state
  logic [CFG_DATA_W-1:0] grid_rows_r, grid_cols_r;
  logic [SPAN_W-1:0]     long_span_r, short_span_r;
  int unsigned           pos_row, pos_col;
  bit                    occ_ring [MAX_SPAN][MAX_COLS];
  logic [CNT_W-1:0]      col_cnt_long [MAX_COLS];
  logic [CNT_W-1:0]      col_cnt_short [MAX_COLS];
  logic [2*CNT_W-1:0]    row_cnt_hist [MAX_SPAN];

  footprint_clearance_window_check_core #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .MAX_SPAN(MAX_SPAN)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cell_occupied    (in_cell_occupied),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_row_index       (out_row_index),
    .out_col_index       (out_col_index),
    .out_fits_lengthwise (out_fits_lengthwise),
    .out_fits_crosswise  (out_fits_crosswise),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int unsigned extent_eff(logic [CFG_DATA_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // span value with random don't-care bits above the register width
  function automatic logic [CFG_DATA_W-1:0] span_word(int unsigned span);
    return {(CFG_DATA_W-SPAN_W)'($urandom()), SPAN_W'(span)};
  endfunction

  task automatic reset_predictor();
    grid_rows_r  = CFG_DATA_W'(EXTENT_RST);
    grid_cols_r  = CFG_DATA_W'(EXTENT_RST);
    long_span_r  = SPAN_W'(SPAN_RST);
    short_span_r = SPAN_W'(SPAN_RST);
    pos_row = 0;
    pos_col = 0;
    foreach (occ_ring[i, j]) occ_ring[i][j] = 1'b0;
    foreach (col_cnt_long[i]) begin
      col_cnt_long[i]  = '0;
      col_cnt_short[i] = '0;
    end
    foreach (row_cnt_hist[i]) row_cnt_hist[i] = '0;
  endtask

  task automatic predict_cell(input logic occ);
    int unsigned      r, c, kl, ks, rows, cols, sum_l, sum_x, d;
    logic             leave_l, leave_s;
    logic [CNT_W-1:0] cl, cs;
    clearance_t       res;
    r    = pos_row;
    c    = pos_col % MAX_COLS;
    kl   = long_span_r;
    ks   = short_span_r;
    rows = extent_eff(grid_rows_r, MAX_ROWS);
    cols = extent_eff(grid_cols_r, MAX_COLS);
    // bit of the row that drops out of each column window
    leave_l = (r >= kl + 1) ? occ_ring[(r - kl - 1) % MAX_SPAN][c] : 1'b0;
    leave_s = (r >= ks + 1) ? occ_ring[(r - ks - 1) % MAX_SPAN][c] : 1'b0;
    occ_ring[r % MAX_SPAN][c] = occ;
    if (r == 0) begin
      cl = CNT_W'(occ);
      cs = CNT_W'(occ);
    end else begin
      cl = col_cnt_long[c] + CNT_W'(occ) - CNT_W'(leave_l);
      cs = col_cnt_short[c] + CNT_W'(occ) - CNT_W'(leave_s);
    end
    col_cnt_long[c]  = cl;
    col_cnt_short[c] = cs;
    row_cnt_hist[c % MAX_SPAN] = {cs, cl};
    sum_l = 0;
    sum_x = 0;
    for (d = 0; d <= ks; d++)
      sum_l += row_cnt_hist[(c + MAX_SPAN - d) % MAX_SPAN][CNT_W-1:0];
    for (d = 0; d <= kl; d++)
      sum_x += row_cnt_hist[(c + MAX_SPAN - d) % MAX_SPAN][2*CNT_W-1:CNT_W];
    res.row   = IDX_W'(r);
    res.col   = IDX_W'(c);
    res.fit_l = (r >= kl + 1) && (c >= ks + 1) && (sum_l == 0);
    res.fit_x = (r >= ks + 1) && (c >= kl + 1) && (sum_x == 0);
    clearance_q.push_back(res);
    if (pos_col + 1 >= cols) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= rows) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  task automatic flag_result(string why, clearance_t want, clearance_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: exp row %0d col %0d len %0b cross %0b, got row %0d col %0d len %0b cross %0b",
               why, want.row, want.col, want.fit_l, want.fit_x,
               got.row, got.col, got.fit_l, got.fit_x);
  endtask

  // cell driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_cell_occupied <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (cell_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid         <= 1'b1;
        in_cell_occupied <= cell_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // register write driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_wdata <= '0;
    end else if (!cfg_valid || cfg_ready) begin
      if (reg_q.size() > 0) begin
        cfg_valid <= 1'b1;
        cfg_index <= reg_q[0].idx;
        cfg_wdata <= reg_q[0].data;
        void'(reg_q.pop_front());
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict from input and register beats
  always @(posedge clk) begin : monitor
    clearance_t got, want;
    if (!rst_n) begin
      reset_predictor();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{row: out_row_index, col: out_col_index,
                fit_l: out_fits_lengthwise, fit_x: out_fits_crosswise};
        if (clearance_q.size() == 0) begin
          flag_result("unexpected beat", '0, got);
        end else begin
          want = clearance_q.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.fit_l !== want.fit_l || got.fit_x !== want.fit_x)
            flag_result("mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        predict_cell(in_cell_occupied);
        cells_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_ROWS:  grid_rows_r  = cfg_wdata;
          REG_GRID_COLS:  grid_cols_r  = cfg_wdata;
          REG_LONG_SPAN:  long_span_r  = cfg_wdata[SPAN_W-1:0];
          REG_SHORT_SPAN: short_span_r = cfg_wdata[SPAN_W-1:0];
          default: ;
        endcase
        regs_taken++;
      end
    end
  end

  task automatic wait_idle();
    while (cells_taken != cells_planned || clearance_q.size() != 0) @(posedge clk);
  endtask

  // registers change only with the pipe drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    reg_q.push_back('{idx: idx, data: data});
    regs_planned++;
    while (regs_taken != regs_planned) @(posedge clk);
  endtask

  task automatic set_grid(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
                          logic [CFG_DATA_W-1:0] lspan, logic [CFG_DATA_W-1:0] sspan);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_GRID_COLS, cols);
    write_reg(REG_LONG_SPAN, lspan);
    write_reg(REG_SHORT_SPAN, sspan);
  endtask

  task automatic push_cells(int unsigned n, int unsigned density);
    repeat (n) cell_q.push_back($urandom_range(99) < density);
    cells_planned += n;
  endtask

  // cells from the current raster position up to the end of the frame;
  // a full frame when sitting at the origin
  task automatic complete_frame(int unsigned density);
    int unsigned rows, cols, n;
    wait_idle();
    rows = extent_eff(grid_rows_r, MAX_ROWS);
    cols = extent_eff(grid_cols_r, MAX_COLS);
    n = (pos_col >= cols) ? 1 : cols - pos_col;
    if (pos_row + 1 < rows) n += (rows - pos_row - 1) * cols;
    push_cells(n, density);
  endtask

  task automatic random_phase();
    int unsigned rows, cols, frames, density, part, start;
    start  = cells_planned;
    rows   = $urandom_range(0, 12);
    cols   = $urandom_range(0, 16);
    frames = $urandom_range(1, 3);
    set_grid(CFG_DATA_W'(rows), CFG_DATA_W'(cols),
             span_word(($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(4)),
             span_word(($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(4)));
    repeat (frames) begin
      case ($urandom_range(3))
        0:       density = 0;
        1:       density = 3;
        2:       density = 10;
        default: density = 40;
      endcase
      rows = extent_eff(grid_rows_r, MAX_ROWS);
      cols = extent_eff(grid_cols_r, MAX_COLS);
      if ($urandom_range(3) == 0 && rows * cols > 1) begin
        // mid-frame rewrite: columns may only shrink
        part = $urandom_range(1, rows * cols - 1);
        push_cells(part, density);
        wait_idle();
        write_reg(REG_GRID_COLS, CFG_DATA_W'($urandom_range(1, cols)));
        write_reg(REG_GRID_ROWS, CFG_DATA_W'($urandom_range(0, 12)));
        write_reg(REG_LONG_SPAN, span_word($urandom_range(5)));
        write_reg(REG_SHORT_SPAN, span_word($urandom_range(5)));
      end
      complete_frame(density);
    end
    wait_idle();
    random_cells += cells_planned - start;
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry, a few cells of row 0
    push_cells(4, 0);
    push_cells(1, 100);
    push_cells(3, 0);
    wait_idle();
    // column extent drops below the counter; spare indexes are ignored
    write_reg(REG_GRID_COLS, CFG_DATA_W'(4));
    write_reg(REG_SPARE_FIRST, '1);
    write_reg(REG_SPARE_LAST, '0);
    push_cells(1, 100);
    push_cells(6, 0);
    wait_idle();
    // row extent below the row counter: frame closes after this row
    write_reg(REG_GRID_ROWS, CFG_DATA_W'(2));
    complete_frame(0);
    // next frame restarts counts at row 0
    complete_frame(100);

    // extreme spans
    set_grid(CFG_DATA_W'(66), CFG_DATA_W'(2), span_word(63), span_word(0));
    complete_frame(1);
    set_grid(CFG_DATA_W'(2), CFG_DATA_W'(66), span_word(0), span_word(63));
    complete_frame(1);
    while (random_cells < 60) random_phase();

    send_gap_pct   = 68;
    recv_stall_pct = 19;
    // single-column frame deeper than the history ring
    set_grid(CFG_DATA_W'(150), '0, span_word($urandom_range(3)),
             span_word($urandom_range(3)));
    complete_frame(50);
    set_grid(CFG_DATA_W'(2), CFG_DATA_W'(66), span_word(63), span_word(0));
    complete_frame(1);
    while (random_cells < 120) random_phase();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    // widest row, single-row frame
    set_grid('0, '1, '1, '0);
    complete_frame(50);
    while (random_cells < 250) random_phase();

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && clearance_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
